// ----- src/assert_macros.svh -----
// Assertion macros shared by the dispatcher RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ERD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ERD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define ERD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/erd_pkg.sv -----
// Package for the elevator request dispatcher: widths, codes, shared types.
// Depends on nothing.
package erd_pkg;

    localparam int NUM_FLOORS_DEFAULT = 5;
    localparam int OP_W               = 2;
    localparam int FLOOR_W            = 6;
    localparam int FLOOR_IW           = FLOOR_W + 1;
    localparam int STATUS_W           = 2;

    typedef enum logic [OP_W-1:0] {
        OP_CABIN = 2'd0,
        OP_HALL  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic                hit;
        logic [FLOOR_IW-1:0] floor;
    } pick_t;

endpackage

// ----- src/erd_req_if.sv -----
// Request channel of the dispatcher: valid/ready and one request item.
// Depends on erd_pkg.
interface erd_req_if;

    logic                        valid;
    logic                        ready;
    logic [erd_pkg::OP_W-1:0]    opcode;
    logic [erd_pkg::FLOOR_W-1:0] floor;
    logic                        hall_up;
    logic [erd_pkg::FLOOR_W-1:0] current_floor;

    modport source (output valid, output opcode, output floor, output hall_up,
                    output current_floor, input ready);
    modport sink   (input valid, input opcode, input floor, input hall_up,
                    input current_floor, output ready);

endinterface

// ----- src/erd_rsp_if.sv -----
// Response channel of the dispatcher: valid/ready and one result item.
// Depends on erd_pkg.
interface erd_rsp_if;

    logic                         valid;
    logic                         ready;
    logic [erd_pkg::FLOOR_W-1:0]  next_floor;
    logic [erd_pkg::STATUS_W-1:0] status;
    logic                         up_pending;
    logic                         down_pending;

    modport source (output valid, output next_floor, output status, output up_pending,
                    output down_pending, input ready);
    modport sink   (input valid, input next_floor, input status, input up_pending,
                    input down_pending, output ready);

endinterface

// ----- src/erd_select.sv -----
// Floor selection over one request bitmap: single request, else nearest in direction.
// Depends on erd_pkg.
module erd_select #(
    parameter int NUM_FLOORS = erd_pkg::NUM_FLOORS_DEFAULT
) (
    input  logic [NUM_FLOORS-1:0]       set,
    input  logic [erd_pkg::FLOOR_W-1:0] cur,
    input  logic                        dir_up,
    output erd_pkg::pick_t              pick,
    output logic [NUM_FLOORS-1:0]       remain
);

    localparam int FW    = erd_pkg::FLOOR_IW;
    localparam int IDX_W = (NUM_FLOORS > 1) ? $clog2(NUM_FLOORS) : 1;

    logic                  single;
    logic [NUM_FLOORS-1:0] masked;
    logic [NUM_FLOORS-1:0] cand;
    logic [IDX_W-1:0]      idx;
    logic [FW-1:0]         cur_ext;

    assign cur_ext = {1'b0, cur};
    assign single  = (set != '0) && ((set & (set - NUM_FLOORS'(1))) == '0);

    always_comb
    begin
        for (int i = 0; i < NUM_FLOORS; i++)
        begin
            if (dir_up)
                masked[i] = set[i] && (FW'(i + 1) > cur_ext);
            else
                masked[i] = set[i] && (FW'(i + 1) < cur_ext);
        end
    end

    assign cand = single ? set : masked;

    always_comb
    begin
        idx = '0;
        if (dir_up || single)
        begin
            for (int i = NUM_FLOORS - 1; i >= 0; i--)
                if (cand[i])
                    idx = IDX_W'(i);
        end
        else
        begin
            for (int i = 0; i < NUM_FLOORS; i++)
                if (cand[i])
                    idx = IDX_W'(i);
        end
    end

    always_comb
    begin
        pick.hit   = (cand != '0);
        pick.floor = pick.hit ? (FW'(idx) + FW'(1)) : '0;
        remain     = set;
        if (single)
            remain = '0;
        else if (pick.hit)
            remain[idx] = 1'b0;
    end

endmodule

// ----- src/elevator_request_dispatcher.sv -----
// Top level of the elevator request dispatcher: input stage, selection, result stage.
// Depends on erd_pkg, erd_req_if, erd_rsp_if, erd_select and assert_macros.svh.
//
//  channel | dir | modport | carries
//  req     | in  | sink    | opcode, floor, hall_up, current_floor
//  rsp     | out | source  | next_floor, status, up_pending, down_pending
//
// One item per cycle while the result register is not stalled; each item is held in the input
// register after the accepting edge and moves to the result register at the first edge on which
// s1_advance is set, so its result is offered in the cycle after that edge.
// The request bitmaps update as an item moves from the input to the result register.
// Reset clears both bitmaps, the direction preference and both valid flags.
// A stalled result register holds the input stage; req.ready drops only then.
`include "assert_macros.svh"

module elevator_request_dispatcher #(
    parameter int NUM_FLOORS = erd_pkg::NUM_FLOORS_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    erd_req_if.sink   req,
    erd_rsp_if.source rsp
);

    localparam int FW = erd_pkg::FLOOR_IW;
    localparam int LW = erd_pkg::FLOOR_W;

    logic                        s1_valid_reg;
    erd_pkg::opcode_t            s1_op_reg;
    logic [LW-1:0]               s1_floor_reg;
    logic                        s1_hall_up_reg;
    logic [LW-1:0]               s1_cur_reg;

    logic [NUM_FLOORS-1:0]       up_reg, up_next;
    logic [NUM_FLOORS-1:0]       down_reg, down_next;
    logic                        prefer_up_reg, prefer_up_next;

    logic                        out_valid_reg;
    logic [LW-1:0]               next_floor_reg, next_floor_next;
    erd_pkg::status_t            status_reg, status_next;
    logic                        up_pend_reg;
    logic                        down_pend_reg;

    logic                        s1_advance;
    logic                        accept;

    erd_pkg::pick_t              up_pick, down_pick;
    logic [NUM_FLOORS-1:0]       up_remain, down_remain;

    logic [FW-1:0]               fl_ext;
    logic                        fl_ok;
    logic                        to_up;
    logic [NUM_FLOORS-1:0]       fl_bit;
    logic                        pref;
    logic [FW-1:0]               served;

    assign s1_advance = !out_valid_reg || rsp.ready;
    assign req.ready  = !s1_valid_reg || s1_advance;
    assign accept     = req.valid && req.ready;

    erd_select #(.NUM_FLOORS(NUM_FLOORS)) u_sel_up (
        .set    (up_reg),
        .cur    (s1_cur_reg),
        .dir_up (1'b1),
        .pick   (up_pick),
        .remain (up_remain)
    );

    erd_select #(.NUM_FLOORS(NUM_FLOORS)) u_sel_down (
        .set    (down_reg),
        .cur    (s1_cur_reg),
        .dir_up (1'b0),
        .pick   (down_pick),
        .remain (down_remain)
    );

    assign fl_ext = {1'b0, s1_floor_reg};
    assign fl_ok  = (fl_ext >= FW'(1)) && (fl_ext <= FW'(NUM_FLOORS));
    assign fl_bit = NUM_FLOORS'(1) << (fl_ext - FW'(1));

    always_comb
    begin
        if (s1_op_reg == erd_pkg::OP_CABIN)
            to_up = (s1_floor_reg >= s1_cur_reg);
        else if (fl_ext == FW'(1))
            to_up = 1'b0;
        else if (fl_ext == FW'(NUM_FLOORS))
            to_up = 1'b1;
        else
            to_up = s1_hall_up_reg;
    end

    always_comb
    begin
        up_next         = up_reg;
        down_next       = down_reg;
        prefer_up_next  = prefer_up_reg;
        status_next     = erd_pkg::ST_OK;
        served          = '0;
        pref            = prefer_up_reg;
        case (s1_op_reg)
            erd_pkg::OP_CABIN, erd_pkg::OP_HALL:
            begin
                if (!fl_ok)
                    status_next = erd_pkg::ST_RANGE;
                else if (to_up)
                    up_next = up_reg | fl_bit;
                else
                    down_next = down_reg | fl_bit;
            end
            erd_pkg::OP_QUERY:
            begin
                if (up_reg == '0)
                    pref = 1'b0;
                if (down_reg == '0)
                    pref = 1'b1;
                if (pref && up_pick.hit)
                begin
                    served         = up_pick.floor;
                    up_next        = up_remain;
                    prefer_up_next = 1'b1;
                end
                else if (!pref && down_pick.hit)
                begin
                    served         = down_pick.floor;
                    down_next      = down_remain;
                    prefer_up_next = 1'b0;
                end
                else if (pref)
                begin
                    served         = down_pick.floor;
                    down_next      = down_remain;
                    prefer_up_next = 1'b0;
                end
                else
                begin
                    served         = up_pick.floor;
                    up_next        = up_remain;
                    prefer_up_next = 1'b1;
                end
                if (served == FW'(1))
                    prefer_up_next = 1'b1;
                else if (served == FW'(NUM_FLOORS))
                    prefer_up_next = 1'b0;
                if (served == '0)
                    status_next = erd_pkg::ST_EMPTY;
            end
            default:
            begin
                status_next = erd_pkg::ST_OK;
            end
        endcase
        next_floor_next = served[LW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            up_reg        <= '0;
            down_reg      <= '0;
            prefer_up_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                s1_valid_reg <= req.valid;
            if (s1_advance)
                out_valid_reg <= s1_valid_reg;
            if (s1_advance && s1_valid_reg)
            begin
                up_reg        <= up_next;
                down_reg      <= down_next;
                prefer_up_reg <= prefer_up_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg      <= erd_pkg::opcode_t'(req.opcode);
            s1_floor_reg   <= req.floor;
            s1_hall_up_reg <= req.hall_up;
            s1_cur_reg     <= req.current_floor;
        end
        if (s1_advance && s1_valid_reg)
        begin
            next_floor_reg <= next_floor_next;
            status_reg     <= status_next;
            up_pend_reg    <= (up_next != '0);
            down_pend_reg  <= (down_next != '0);
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.next_floor   = next_floor_reg;
    assign rsp.status       = status_reg;
    assign rsp.up_pending   = up_pend_reg;
    assign rsp.down_pending = down_pend_reg;

    `ERD_ASSERT_IMPLY(a_empty_no_floor, clk, rst_n, out_valid_reg && (status_reg == erd_pkg::ST_EMPTY), next_floor_reg == '0, "empty status with nonzero floor")
    `ERD_ASSERT_NEXT(a_range_keeps_state, clk, rst_n, s1_valid_reg && s1_advance && (status_next == erd_pkg::ST_RANGE), $stable(up_reg) && $stable(down_reg), "range error changed requests")
    `ERD_ASSERT_NEXT(a_idle_query_down, clk, rst_n, s1_valid_reg && s1_advance && (s1_op_reg == erd_pkg::OP_QUERY) && (up_reg == '0) && (down_reg == '0), !prefer_up_reg && (status_reg == erd_pkg::ST_EMPTY), "empty query mishandled")
    `ERD_ASSERT_NEXT(a_stall_holds, clk, rst_n, s1_valid_reg && !s1_advance, s1_valid_reg && out_valid_reg, "stalled item dropped")

endmodule
